FILE: rtl/blg_pkg.sv
// Shared item codes and fixed widths for the line generator.
package blg_pkg;

    localparam int COLOR_BITS = 12;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

endpackage

FILE: rtl/blg_front.sv
// Front end: input handshake and start-item setup (step directions and absolute deltas).
module blg_front #(
    parameter int COORD_BITS = 8
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_q_full,
    output logic                  o_push,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic [COORD_BITS-1:0] o_abs_dx,
    output logic [COORD_BITS-1:0] o_abs_dy,
    output logic                  o_x_neg,
    output logic                  o_y_neg
);
    import blg_pkg::*;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // The direction comes from the compare, the magnitude from the matching subtraction.
    assign o_x_neg  = i_x_end < i_x_start;
    assign o_y_neg  = i_y_end < i_y_start;
    assign o_abs_dx = o_x_neg ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
    assign o_abs_dy = o_y_neg ? (i_y_start - i_y_end) : (i_y_end - i_y_start);

endmodule

FILE: rtl/blg_fifo.sv
// Small register queue between the front end and the line walker.
module blg_fifo #(
    parameter int DATA_W     = 63,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);
    import blg_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [DATA_W-1:0]     r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr_ptr;
    logic [DEPTH_LOG2-1:0] r_rd_ptr;
    logic [DEPTH_LOG2:0]   r_count;
    logic                  do_pop;

    assign o_full  = r_count == (DEPTH_LOG2 + 1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + DEPTH_LOG2'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + DEPTH_LOG2'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (DEPTH_LOG2 + 1)'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - (DEPTH_LOG2 + 1)'(1);
            end
        end
    end

endmodule

FILE: rtl/blg_back.sv
// Back end: Bresenham walk state, per-item stepping and the output register.
module blg_back #(
    parameter int COORD_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    output logic                             o_pop,
    input  blg_pkg::t_kind                   i_kind,
    input  logic [COORD_BITS-1:0]            i_x_start,
    input  logic [COORD_BITS-1:0]            i_y_start,
    input  logic [COORD_BITS-1:0]            i_x_end,
    input  logic [COORD_BITS-1:0]            i_y_end,
    input  logic [blg_pkg::COLOR_BITS-1:0]   i_color,
    input  logic [COORD_BITS-1:0]            i_abs_dx,
    input  logic [COORD_BITS-1:0]            i_abs_dy,
    input  logic                             i_x_neg,
    input  logic                             i_y_neg,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [COORD_BITS-1:0]            o_pixel_x,
    output logic [COORD_BITS-1:0]            o_pixel_y,
    output logic [blg_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                             o_last_pixel
);
    import blg_pkg::*;

    localparam int TW_W  = COORD_BITS + 1;
    localparam int ERR_W = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    logic                  r_busy;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic [COORD_BITS-1:0] r_tgt_x;
    logic [COORD_BITS-1:0] r_tgt_y;
    logic [TW_W-1:0]       r_twice_dx;
    logic [TW_W-1:0]       r_twice_dy;
    logic                  r_x_neg;
    logic                  r_y_neg;
    logic                  r_x_major;
    logic [ERR_W-1:0]      r_err;
    logic [COLOR_BITS-1:0] r_color;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [COLOR_BITS-1:0] r_pc;
    logic                  r_last;

    logic                  is_start;
    logic                  emit;
    logic                  st_x_major;
    logic [ERR_W-1:0]      st_err;
    logic                  st_last;
    logic                  err_ge;
    logic                  move_x;
    logic                  move_y;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic [TW_W-1:0]       major_inc;
    logic [TW_W-1:0]       minor_dec;
    logic [ERR_W-1:0]      step_err;
    logic                  step_last;
    logic [COORD_BITS-1:0] n_px;
    logic [COORD_BITS-1:0] n_py;
    logic                  n_last;

    assign is_start = i_kind == KIND_START;
    assign o_pop    = i_q_valid && (!r_out_valid || i_ready);
    // A step item that finds no active line is consumed without a result.
    assign emit     = o_pop && (is_start || r_busy);

    // Start setup: ties between the deltas walk along y.
    assign st_x_major = i_abs_dx > i_abs_dy;
    assign st_err = st_x_major ? ({2'b00, i_abs_dy, 1'b0} - {3'b000, i_abs_dx})
                               : ({2'b00, i_abs_dx, 1'b0} - {3'b000, i_abs_dy});
    assign st_last = (i_x_start == i_x_end) && (i_y_start == i_y_end);

    // One walk step: always move on the major axis, on the minor one when the error is
    // non-negative.
    assign err_ge    = !r_err[ERR_W-1];
    assign move_x    = r_x_major || err_ge;
    assign move_y    = !r_x_major || err_ge;
    assign step_x    = move_x ? (r_cur_x + (r_x_neg ? {COORD_BITS{1'b1}} : ONE)) : r_cur_x;
    assign step_y    = move_y ? (r_cur_y + (r_y_neg ? {COORD_BITS{1'b1}} : ONE)) : r_cur_y;
    assign major_inc = r_x_major ? r_twice_dy : r_twice_dx;
    assign minor_dec = r_x_major ? r_twice_dx : r_twice_dy;
    assign step_err  = r_err + {2'b00, major_inc} - (err_ge ? {2'b00, minor_dec} : '0);
    assign step_last = r_x_major ? (step_x == r_tgt_x) : (step_y == r_tgt_y);

    assign n_px   = is_start ? i_x_start : step_x;
    assign n_py   = is_start ? i_y_start : step_y;
    assign n_last = is_start ? st_last : step_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_busy <= !n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (is_start) begin
                r_cur_x    <= i_x_start;
                r_cur_y    <= i_y_start;
                r_tgt_x    <= i_x_end;
                r_tgt_y    <= i_y_end;
                r_twice_dx <= {i_abs_dx, 1'b0};
                r_twice_dy <= {i_abs_dy, 1'b0};
                r_x_neg    <= i_x_neg;
                r_y_neg    <= i_y_neg;
                r_x_major  <= st_x_major;
                r_err      <= st_err;
                r_color    <= i_color;
            end else if (r_busy) begin
                r_cur_x <= step_x;
                r_cur_y <= step_y;
                r_err   <= step_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_pc   <= is_start ? i_color : r_color;
            r_last <= n_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_last_pixel  = r_last;

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && n_last |=> !r_busy)
        else $error("line still active after its last pixel");

    a_major_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_x_major ? (r_cur_x != r_tgt_x) : (r_cur_y != r_tgt_y)))
        else $error("active line already sits on its end point");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !emit |=> !r_out_valid)
        else $error("step item on an idle line produced a pixel");

endmodule

FILE: rtl/bresenham_line_generator.sv
// Bresenham line generator: a start item loads two endpoints and a color and emits
// the start pixel; each step item emits the next pixel of the line until the end
// point, which is flagged with last_pixel. Steps with no active line are dropped,
// and a start item abandons any active line. The block takes one item per clock
// while its queue has room, and gives at most one pixel per item; an item's pixel
// passes through the four-entry queue and then the output register. Input ready
// drops only when that queue is full, which happens only while the output side
// stalls; each walk step is computed combinationally in the back end.
module bresenham_line_generator #(
    parameter int COORD_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [COORD_BITS-1:0]          i_x_start,
    input  logic [COORD_BITS-1:0]          i_y_start,
    input  logic [COORD_BITS-1:0]          i_x_end,
    input  logic [COORD_BITS-1:0]          i_y_end,
    input  logic [blg_pkg::COLOR_BITS-1:0] i_line_color,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic [blg_pkg::COLOR_BITS-1:0] o_pixel_color,
    output logic                           o_last_pixel
);
    import blg_pkg::*;

    localparam int Q_W        = 6 * COORD_BITS + COLOR_BITS + 3;
    localparam int DEPTH_LOG2 = 2;

    logic                  q_full;
    logic                  q_push;
    logic                  q_valid;
    logic                  q_pop;
    logic [Q_W-1:0]        q_wdata;
    logic [Q_W-1:0]        q_rdata;

    logic [COORD_BITS-1:0] f_abs_dx;
    logic [COORD_BITS-1:0] f_abs_dy;
    logic                  f_x_neg;
    logic                  f_y_neg;

    logic                  b_kind_bit;
    logic [COORD_BITS-1:0] b_x_start;
    logic [COORD_BITS-1:0] b_y_start;
    logic [COORD_BITS-1:0] b_x_end;
    logic [COORD_BITS-1:0] b_y_end;
    logic [COLOR_BITS-1:0] b_color;
    logic [COORD_BITS-1:0] b_abs_dx;
    logic [COORD_BITS-1:0] b_abs_dy;
    logic                  b_x_neg;
    logic                  b_y_neg;

    blg_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .i_x_start(i_x_start),
        .i_y_start(i_y_start),
        .i_x_end  (i_x_end),
        .i_y_end  (i_y_end),
        .o_abs_dx (f_abs_dx),
        .o_abs_dy (f_abs_dy),
        .o_x_neg  (f_x_neg),
        .o_y_neg  (f_y_neg)
    );

    assign q_wdata = {i_kind, i_x_start, i_y_start, i_x_end, i_y_end, i_line_color,
                      f_abs_dx, f_abs_dy, f_x_neg, f_y_neg};

    blg_fifo #(
        .DATA_W    (Q_W),
        .DEPTH_LOG2(DEPTH_LOG2)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_data (q_rdata)
    );

    assign {b_kind_bit, b_x_start, b_y_start, b_x_end, b_y_end, b_color,
            b_abs_dx, b_abs_dy, b_x_neg, b_y_neg} = q_rdata;

    blg_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_pop        (q_pop),
        .i_kind       (t_kind'(b_kind_bit)),
        .i_x_start    (b_x_start),
        .i_y_start    (b_y_start),
        .i_x_end      (b_x_end),
        .i_y_end      (b_y_end),
        .i_color      (b_color),
        .i_abs_dx     (b_abs_dx),
        .i_abs_dy     (b_abs_dy),
        .i_x_neg      (b_x_neg),
        .i_y_neg      (b_y_neg),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_color(o_pixel_color),
        .o_last_pixel (o_last_pixel)
    );

endmodule
